/* rtl/rhpc_pkg.sv */
// Package for the RGB / hue-saturation-value pixel converter.
// Holds payload and internal pipeline types, scale constants and small helpers.
// Depends on nothing; every other file of the block imports it.
package rhpc_pkg;

  typedef struct packed {
    logic signed [15:0] first_in;
    logic signed [15:0] second_in;
    logic signed [15:0] third_in;
  } pix_in_t;

  typedef struct packed {
    logic signed [15:0] first_out;
    logic signed [15:0] second_out;
    logic signed [15:0] third_out;
    logic               range_error;
  } pix_out_t;

  // Divider geometry: quotient bits, numerator and denominator widths.
  localparam int QW = 17;
  localparam int NW = 48;
  localparam int DW = 32;

  localparam logic [15:0] SCALE_BYTE = 16'd255;
  localparam logic [15:0] SCALE_HALF = 16'd32767;
  localparam logic [29:0] SQ_BYTE    = 30'd65025;
  localparam logic [29:0] SQ_HALF    = 30'd1073676289;

  // Reverse numerators are biased by 65536 * M^2 plus the rounding term M^2 - 1,
  // so the divider only ever sees non-negative values.
  localparam logic [NW-1:0] BIAS_BYTE = NW'(SQ_BYTE) * NW'(65537) - NW'(1);
  localparam logic [NW-1:0] BIAS_HALF = NW'(SQ_HALF) * NW'(65537) - NW'(1);
  localparam logic [QW-1:0] Q_OFFSET  = QW'(32768);

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  // Per-request control that rides alongside the divider.
  typedef struct packed {
    logic               dir;
    logic               fmt;
    logic               err;
    logic               spec;
    sector_t            sec;
    logic signed [15:0] val;
  } side_t;

  typedef struct packed {
    logic [NW-1:0] num;
    logic [DW-1:0] den;
  } div_in_t;

  function automatic logic [15:0] scale(input logic fmt);
    return fmt ? SCALE_HALF : SCALE_BYTE;
  endfunction

  function automatic logic [29:0] scale_sq(input logic fmt);
    return fmt ? SQ_HALF : SQ_BYTE;
  endfunction

  function automatic logic [NW-1:0] num_bias(input logic fmt);
    return fmt ? BIAS_HALF : BIAS_BYTE;
  endfunction

  function automatic logic [17:0] sector_edge(input logic [2:0] j, input logic fmt);
    return 18'(j) * 18'(scale(fmt));
  endfunction

endpackage

/* rtl/rhpc_prep.sv */
// Front end of the converter: sample conditioning, sector selection and the
// products that form the divider operands, in four register stages.
// Depends on rhpc_pkg.
module rhpc_prep (
  input  logic                     clk,
  input  logic [3:0]               adv,
  input  logic                     cfg_dir,
  input  logic                     cfg_fmt,
  input  logic                     cfg_clamp,
  input  rhpc_pkg::pix_in_t        pix,
  output rhpc_pkg::side_t          side,
  output rhpc_pkg::div_in_t [2:0]  opnd
);
  import rhpc_pkg::*;

  function automatic logic signed [15:0] cond_sample(input logic [15:0] x, input logic fmt,
                                                     input logic clamp);
    logic signed [15:0] r;
    if (!fmt) begin
      r = $signed({8'd0, x[7:0]});
    end else if (clamp && x[15]) begin
      r = '0;
    end else begin
      r = $signed(x);
    end
    return r;
  endfunction

  // Stage 1: conditioned samples.
  logic               c1_err;
  logic signed [15:0] c1_v [3];
  logic               s1_dir, s1_fmt, s1_err;
  logic signed [15:0] s1_v [3];

  always_comb begin
    c1_v[0] = cond_sample(pix.first_in, cfg_fmt, cfg_clamp);
    c1_v[1] = cond_sample(pix.second_in, cfg_fmt, cfg_clamp);
    c1_v[2] = cond_sample(pix.third_in, cfg_fmt, cfg_clamp);
    if (cfg_dir) begin
      c1_err = c1_v[0][15] || c1_v[1][15];
    end else begin
      c1_err = c1_v[0][15] || c1_v[1][15] || c1_v[2][15];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_dir <= cfg_dir;
      s1_fmt <= cfg_fmt;
      s1_err <= c1_err;
      s1_v   <= c1_v;
    end
  end

  // Stage 2: max/mid/min and hue numerator, or sector and first products.
  logic signed [15:0] r, g, b, mx, md, mn;
  logic signed [16:0] d_c, n_c, m_minus_s;
  logic signed [20:0] d21, n21, num_c;
  logic               spec_c;
  logic [17:0]        six_h;
  logic [2:0]         k_c;
  logic [15:0]        f_c;
  logic signed [32:0] a_c, b_c;

  side_t              s2_side;
  logic signed [16:0] s2_d;
  logic signed [20:0] s2_num;
  logic [15:0]        s2_f;
  logic signed [32:0] s2_a, s2_b;
  logic signed [15:0] s2_i;

  always_comb begin
    r = s1_v[0];
    g = s1_v[1];
    b = s1_v[2];
    if (r > g && r > b) begin
      mx = r;
      md = (g > b) ? g : b;
      mn = (g < b) ? g : b;
    end else if (g > b) begin
      mx = g;
      md = (r > b) ? r : b;
      mn = (r < b) ? r : b;
    end else begin
      mx = b;
      md = (r > g) ? r : g;
      mn = (r < g) ? r : g;
    end
    d_c = 17'(mx) - 17'(mn);
    n_c = 17'(md) - 17'(mn);
    d21 = 21'(d_c);
    n21 = 21'(n_c);
    if (r == mx) begin
      num_c = (md == g) ? n21 : d21 * 21'sd6 - n21;
    end else if (g == mx) begin
      num_c = (md == b) ? d21 * 21'sd2 + n21 : d21 * 21'sd2 - n21;
    end else begin
      num_c = (md == r) ? d21 * 21'sd4 + n21 : d21 * 21'sd4 - n21;
    end

    // Reverse: the sector is the number of sector edges that six times hue reaches.
    six_h = {2'b00, s1_v[0]} * 18'd6;
    k_c = 3'd0;
    for (int j = 1; j <= 5; j++) begin
      if (six_h >= sector_edge(3'(j), s1_fmt)) begin
        k_c = 3'(j);
      end
    end
    f_c = 16'(six_h - sector_edge(k_c, s1_fmt));
    m_minus_s = $signed({1'b0, scale(s1_fmt)}) - 17'(s1_v[1]);
    a_c = s1_v[2] * m_minus_s;
    b_c = s1_v[2] * 17'(s1_v[1]);

    if (s1_dir) begin
      spec_c = (s1_v[2] == 16'sd0) || (s1_v[1] == 16'sd0);
    end else begin
      spec_c = (mx == 16'sd0) || (mx == mn);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_side.dir  <= s1_dir;
      s2_side.fmt  <= s1_fmt;
      s2_side.err  <= s1_err;
      s2_side.spec <= spec_c;
      s2_side.sec  <= sector_t'(k_c);
      s2_side.val  <= s1_dir ? s1_v[2] : mx;
      s2_d         <= d_c;
      s2_num       <= num_c;
      s2_f         <= f_c;
      s2_a         <= a_c;
      s2_b         <= b_c;
      s2_i         <= s1_v[2];
    end
  end

  // Stage 3: products by the scale, by the fraction and by the square of the scale.
  logic signed [16:0] m17;
  logic signed [47:0] p_c, q_c, am_c, bf_c, im_c;
  logic [19:0]        den1_c;

  side_t              s3_side;
  logic signed [47:0] s3_p, s3_q, s3_am, s3_bf, s3_im;
  logic [19:0]        s3_den1;

  always_comb begin
    m17    = $signed({1'b0, scale(s2_side.fmt)});
    p_c    = s2_d * m17;
    q_c    = s2_num * m17;
    den1_c = 20'(s2_d) * 20'd6;
    am_c   = s2_a * m17;
    bf_c   = s2_b * $signed({1'b0, s2_f});
    im_c   = s2_i * $signed({1'b0, scale_sq(s2_side.fmt)});
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_side <= s2_side;
      s3_p    <= p_c;
      s3_q    <= q_c;
      s3_den1 <= den1_c;
      s3_am   <= am_c;
      s3_bf   <= bf_c;
      s3_im   <= im_c;
    end
  end

  // Stage 4: divider operands.
  logic signed [47:0] nn [3];
  logic [DW-1:0]      rden;
  logic               no_div;
  div_in_t [2:0]      opnd_c;

  always_comb begin
    nn[0]  = s3_am;
    nn[1]  = s3_am + s3_bf;
    nn[2]  = s3_im - s3_bf;
    rden   = {1'b0, scale_sq(s3_side.fmt), 1'b0};
    no_div = s3_side.spec || s3_side.err;
    if (s3_side.dir) begin
      for (int j = 0; j < 3; j++) begin
        opnd_c[j].num = NW'(nn[j] <<< 1) + num_bias(s3_side.fmt);
        opnd_c[j].den = rden;
      end
    end else begin
      opnd_c[0].num = NW'(s3_p);
      opnd_c[0].den = no_div ? DW'(1) : {16'd0, s3_side.val};
      opnd_c[1].num = NW'(s3_q);
      opnd_c[1].den = no_div ? DW'(1) : {12'd0, s3_den1};
      opnd_c[2].num = '0;
      opnd_c[2].den = DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      side <= s3_side;
      opnd <= opnd_c;
    end
  end

endmodule

/* rtl/rhpc_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on rhpc_pkg for the operand type and widths.
module rhpc_div (
  input  logic                     clk,
  input  logic [rhpc_pkg::QW-1:0]  adv,
  input  rhpc_pkg::div_in_t        opnd,
  output logic [rhpc_pkg::QW-1:0]  quo
);
  import rhpc_pkg::*;

  logic [NW-1:0] rem     [QW];
  logic [DW-1:0] den     [QW];
  logic [QW-1:0] q       [QW];
  logic [NW-1:0] src_rem [QW];
  logic [DW-1:0] src_den [QW];
  logic [QW-1:0] src_q   [QW];
  logic [NW:0]   trial   [QW];
  logic [NW-1:0] rem_nx  [QW];
  logic [QW-1:0] q_nx    [QW];

  always_comb begin
    src_rem[0] = opnd.num;
    src_den[0] = opnd.den;
    src_q[0]   = '0;
    for (int st = 1; st < QW; st++) begin
      src_rem[st] = rem[st-1];
      src_den[st] = den[st-1];
      src_q[st]   = q[st-1];
    end
    // Stage st decides quotient bit QW-1-st.
    for (int st = 0; st < QW; st++) begin
      trial[st]  = {1'b0, src_rem[st]} - ((NW+1)'(src_den[st]) << (QW - 1 - st));
      rem_nx[st] = trial[st][NW] ? src_rem[st] : trial[st][NW-1:0];
      q_nx[st]   = src_q[st];
      q_nx[st][QW-1-st] = !trial[st][NW];
    end
  end

  always_ff @(posedge clk) begin
    for (int st = 0; st < QW; st++) begin
      if (adv[st]) begin
        rem[st] <= rem_nx[st];
        den[st] <= src_den[st];
        q[st]   <= q_nx[st];
      end
    end
  end

  assign quo = q[QW-1];

endmodule

/* rtl/rgb_hsv_pixel_converter.sv */
// Top level of the RGB / hue-saturation-value pixel converter.
// Depends on rhpc_pkg, rhpc_prep and rhpc_div.
//
// Usage: a pixel request enters on req_valid/req_ready/req_data and its result
// leaves on res_valid/res_ready/res_data; both channels complete a transfer at a
// clock edge where valid and ready are high. The APB port holds three registers:
// direction at 0x0, sample format at 0x4 and negative clamp at 0x8. They are to
// be changed only while the pipeline is empty; the block does not enforce it.
// The pipeline has four front-end stages, seventeen divider stages (one quotient
// bit each) and an output register. Throughput is one request per clock while
// the receiver keeps up; the seventeen-stage restoring divider sets the depth,
// not the rate. Every stage carries a valid bit and moves when the stage after
// it is empty or moving, so bubbles are squeezed out and requests keep entering
// while a result waits at the output. When the receiver stalls, the pipeline
// fills up and req_ready falls only once every stage holds a request; nothing
// is dropped or repeated. Synchronous reset empties the pipeline and clears
// the registers to forward conversion of unsigned bytes with no clamping.
module rgb_hsv_pixel_converter (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  rhpc_pkg::pix_in_t   req_data,
  output logic                res_valid,
  input  logic                res_ready,
  output rhpc_pkg::pix_out_t  res_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rhpc_pkg::*;

  localparam int PREP  = 4;
  localparam int TOTAL = PREP + QW + 1;

  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_FORMAT    = 2'd1;
  localparam logic [1:0] REG_CLAMP     = 2'd2;

  // Configuration registers.
  logic cfg_dir, cfg_fmt, cfg_clamp;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_dir   <= 1'b0;
      cfg_fmt   <= 1'b0;
      cfg_clamp <= 1'b0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_DIRECTION: cfg_dir   <= pwdata[0];
        REG_FORMAT:    cfg_fmt   <= pwdata[0];
        REG_CLAMP:     cfg_clamp <= pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DIRECTION: prdata = {31'd0, cfg_dir};
      REG_FORMAT:    prdata = {31'd0, cfg_fmt};
      REG_CLAMP:     prdata = {31'd0, cfg_clamp};
      default:       prdata = '0;
    endcase
  end

  // Valid bits and per-stage advance. A stage loads when it is empty or when
  // its contents move on in the same cycle.
  logic [TOTAL-1:0] vld, rdy;

  always_comb begin
    rdy[TOTAL-1] = !vld[TOTAL-1] || res_ready;
    for (int k = TOTAL - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= req_valid;
      end
      for (int k = 1; k < TOTAL; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign req_ready = rdy[0];
  assign res_valid = vld[TOTAL-1];

  // Front end.
  side_t         side;
  div_in_t [2:0] opnd;

  rhpc_prep u_prep (
    .clk       (clk),
    .adv       (rdy[PREP-1:0]),
    .cfg_dir   (cfg_dir),
    .cfg_fmt   (cfg_fmt),
    .cfg_clamp (cfg_clamp),
    .pix       (req_data),
    .side      (side),
    .opnd      (opnd)
  );

  // Three dividers: saturation and hue going forward; the low, rising and
  // falling channel values going back.
  logic [QW-1:0] quo [3];

  for (genvar u = 0; u < 3; u++) begin : g_div
    rhpc_div u_div (
      .clk  (clk),
      .adv  (rdy[PREP +: QW]),
      .opnd (opnd[u]),
      .quo  (quo[u])
    );
  end

  // Control fields follow the requests through the divider stages.
  side_t side_d [QW];

  always_ff @(posedge clk) begin
    if (rdy[PREP]) begin
      side_d[0] <= side;
    end
    for (int st = 1; st < QW; st++) begin
      if (rdy[PREP+st]) begin
        side_d[st] <= side_d[st-1];
      end
    end
  end

  // Output selection. Reverse quotients carry an offset of 32768 that lets
  // negative values pass through the unsigned divider.
  side_t              sd;
  logic signed [15:0] full, low, rise, fall;
  pix_out_t           res_c;

  always_comb begin
    sd   = side_d[QW-1];
    full = sd.val;
    low  = $signed(16'(quo[0] - Q_OFFSET));
    rise = $signed(16'(quo[1] - Q_OFFSET));
    fall = $signed(16'(quo[2] - Q_OFFSET));
    res_c = '0;
    if (sd.err) begin
      res_c.range_error = 1'b1;
    end else if (!sd.dir) begin
      res_c.third_out = sd.val;
      if (!sd.spec) begin
        res_c.first_out  = $signed(quo[1][15:0]);
        res_c.second_out = $signed(quo[0][15:0]);
      end
    end else if (sd.spec) begin
      res_c.first_out  = full;
      res_c.second_out = full;
      res_c.third_out  = full;
    end else begin
      case (sd.sec)
        SEC_RED: begin
          res_c.first_out = full; res_c.second_out = rise; res_c.third_out = low;
        end
        SEC_YELLOW: begin
          res_c.first_out = fall; res_c.second_out = full; res_c.third_out = low;
        end
        SEC_GREEN: begin
          res_c.first_out = low; res_c.second_out = full; res_c.third_out = rise;
        end
        SEC_CYAN: begin
          res_c.first_out = low; res_c.second_out = fall; res_c.third_out = full;
        end
        SEC_BLUE: begin
          res_c.first_out = rise; res_c.second_out = low; res_c.third_out = full;
        end
        default: begin
          res_c.first_out = full; res_c.second_out = low; res_c.third_out = fall;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[TOTAL-1]) begin
      res_data <= res_c;
    end
  end

endmodule

/* bench/rgb_hsv_pixel_converter_test.sv */
// Self-checking bench for the RGB / hue-saturation-value pixel converter.
// Depends on rhpc_pkg and the top level rgb_hsv_pixel_converter.
module rgb_hsv_pixel_converter_test;
  import rhpc_pkg::*;

  localparam int LATENCY = 22;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [3:0] ADDR_DIRECTION = 4'h0;
  localparam logic [3:0] ADDR_FORMAT    = 4'h4;
  localparam logic [3:0] ADDR_CLAMP     = 4'h8;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  pix_in_t req_data = '0;
  logic res_valid;
  logic res_ready = 0;
  pix_out_t res_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rgb_hsv_pixel_converter u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // The bench keeps its own shadow of the three mode registers.
  logic cfg_reverse = 0, cfg_half = 0, cfg_clamp = 0;

  pix_out_t pending_pixels[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;   // chance, in percent, that the sender idles before sending
  int recv_stall_pct = 0;  // chance, in percent, that the receiver is not ready
  int hold_off_cycles = 0; // when nonzero, the receiver stays low this long

  // Rounds n/d to nearest with exact halves going toward minus infinity.
  function automatic longint nearest_half_down(longint n, longint d);
    longint q, r;
    q = n / d;
    r = n % d;
    if (r < 0) begin
      q -= 1;
      r += d;
    end
    if (2 * r > d) q += 1;
    return q;
  endfunction

  // Predicts the converter output for one pixel under the shadow registers.
  function automatic pix_out_t convert_pixel(pix_in_t px);
    pix_out_t o;
    longint v[3], res[3], m;
    longint mx, md, mn, d, n, num, k, f, msq, low, rise, fall, h, s, i;
    logic reject;
    o = '0;
    res[0] = 0; res[1] = 0; res[2] = 0;
    reject = 0;
    m = cfg_half ? 32767 : 255;
    v[0] = cfg_half ? longint'(px.first_in)  : longint'(px.first_in[7:0]);
    v[1] = cfg_half ? longint'(px.second_in) : longint'(px.second_in[7:0]);
    v[2] = cfg_half ? longint'(px.third_in)  : longint'(px.third_in[7:0]);
    if (cfg_half && cfg_clamp)
      for (int j = 0; j < 3; j++) if (v[j] < 0) v[j] = 0;
    if (!cfg_reverse) begin
      if (v[0] < 0 || v[1] < 0 || v[2] < 0) begin
        reject = 1;
      end else begin
        // Red wins only when strictly largest; then green only when larger than blue.
        if (v[0] > v[1] && v[0] > v[2]) begin
          mx = v[0]; md = (v[1] > v[2]) ? v[1] : v[2]; mn = (v[1] < v[2]) ? v[1] : v[2];
        end else if (v[1] > v[2]) begin
          mx = v[1]; md = (v[0] > v[2]) ? v[0] : v[2]; mn = (v[0] < v[2]) ? v[0] : v[2];
        end else begin
          mx = v[2]; md = (v[0] > v[1]) ? v[0] : v[1]; mn = (v[0] < v[1]) ? v[0] : v[1];
        end
        res[2] = mx;
        if (mx != 0 && mx != mn) begin
          res[1] = (m * (mx - mn)) / mx;
          d = mx - mn;
          n = md - mn;
          if (v[0] == mx) num = (md == v[1]) ? n : 6 * d - n;
          else if (v[1] == mx) num = (md == v[2]) ? 2 * d + n : 2 * d - n;
          else num = (md == v[0]) ? 4 * d + n : 4 * d - n;
          res[0] = (m * num) / (6 * d);
        end
      end
    end else begin
      h = v[0]; s = v[1]; i = v[2];
      if (h < 0 || s < 0) begin
        reject = 1;
      end else if (i == 0) begin
        // Black regardless of hue and saturation.
      end else if (s == 0) begin
        res[0] = i; res[1] = i; res[2] = i;
      end else begin
        k = (6 * h) / m;
        if (k > 5) k = 5;
        f = 6 * h - k * m;
        msq = m * m;
        low  = nearest_half_down(i * (m - s) * m, msq);
        rise = nearest_half_down(i * (m - s) * m + i * s * f, msq);
        fall = nearest_half_down(i * msq - i * s * f, msq);
        case (sector_t'(k))
          SEC_RED:    begin res[0] = i;    res[1] = rise; res[2] = low;  end
          SEC_YELLOW: begin res[0] = fall; res[1] = i;    res[2] = low;  end
          SEC_GREEN:  begin res[0] = low;  res[1] = i;    res[2] = rise; end
          SEC_CYAN:   begin res[0] = low;  res[1] = fall; res[2] = i;    end
          SEC_BLUE:   begin res[0] = rise; res[1] = low;  res[2] = i;    end
          default:    begin res[0] = i;    res[1] = low;  res[2] = fall; end
        endcase
      end
    end
    if (!reject) begin
      o.first_out  = 16'(res[0]);
      o.second_out = 16'(res[1]);
      o.third_out  = 16'(res[2]);
    end
    o.range_error = reject;
    return o;
  endfunction

  // Global cycle watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("rgb_hsv_pixel_converter: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls, plus an optional long hold-off counted here.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 0;
    end else if (hold_off_cycles > 0) begin
      res_ready <= 0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checker: each accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    pix_out_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected result %h", $time, res_data);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (res_data.first_out !== want.first_out)
          $display("%0t first_out expected %0d got %0d", $time, want.first_out,
                   res_data.first_out);
        if (res_data.second_out !== want.second_out)
          $display("%0t second_out expected %0d got %0d", $time, want.second_out,
                   res_data.second_out);
        if (res_data.third_out !== want.third_out)
          $display("%0t third_out expected %0d got %0d", $time, want.third_out,
                   res_data.third_out);
        if (res_data.range_error !== want.range_error)
          $display("%0t range_error expected %0b got %0b", $time, want.range_error,
                   res_data.range_error);
        if (res_data !== want) errors++;
      end
    end
  end

  // Sends one pixel request, idling first at the current rate; the
  // prediction is queued at the accepting edge. Valid stays high after the
  // accepting edge; the next request or a mode change takes it from there.
  task automatic send_pixel(pix_in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1;
    req_data <= px;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_pixels.push_back(convert_pixel(px));
  endtask

  // Sends a burst back to back, keeping valid high between requests.
  task automatic send_burst(int count);
    pix_in_t px;
    for (int j = 0; j < count; j++) begin
      px = random_pixel();
      req_valid <= 1;
      req_data <= px;
      @(posedge clk);
      while (!req_ready) @(posedge clk);
      pending_pixels.push_back(convert_pixel(px));
    end
  endtask

  // One write; the bus is left selected so that writes can follow directly.
  task automatic apb_write(logic [3:0] addr, logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Waits for the pipeline to drain, then rewrites all three registers.
  task automatic set_mode(logic rev, logic half, logic clamp);
    req_valid <= 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    apb_write(ADDR_DIRECTION, 32'(rev));
    apb_write(ADDR_FORMAT, 32'(half));
    apb_write(ADDR_CLAMP, 32'(clamp));
    psel <= 0; penable <= 0; pwrite <= 0;
    cfg_reverse = rev;
    cfg_half = half;
    cfg_clamp = clamp;
  endtask

  // Random field value: mostly in-range for the mode, sometimes any pattern.
  function automatic logic [15:0] random_sample(logic hue_field);
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 16'($urandom);
    if (pick == 1) return cfg_half ? 16'h7fff : 16'h00ff;
    if (pick == 2) return 16'h0;
    if (!cfg_half) return {8'($urandom), 8'($urandom)};
    if (hue_field && pick == 3) return 16'(32767 - $urandom_range(3));
    return 16'($urandom_range(32767));
  endfunction

  function automatic pix_in_t random_pixel();
    pix_in_t px;
    px.first_in = random_sample(1);
    px.second_in = random_sample(0);
    px.third_in = random_sample(0);
    // Occasional gray and tie patterns exercise the sector ordering.
    if ($urandom_range(9) == 0) px.second_in = px.first_in;
    if ($urandom_range(9) == 0) px.third_in = px.first_in;
    return px;
  endfunction

  task automatic send_values(int a, int b, int c);
    pix_in_t px;
    px.first_in = 16'(a);
    px.second_in = 16'(b);
    px.third_in = 16'(c);
    send_pixel(px);
  endtask

  task automatic test_forward_bytes();
    set_mode(0, 0, 0);
    send_values(0, 0, 0);
    send_values(255, 255, 255);
    send_values(128, 128, 128);
    send_values(255, 0, 0);
    send_values(255, 255, 0);
    send_values(255, 0, 255);
    send_values(0, 255, 255);
    send_values(10, 200, 90);
    send_values(90, 10, 200);
    send_values(16'hff01, 16'h80fe, 16'h7f7f);
  endtask

  task automatic test_reverse_bytes();
    set_mode(1, 0, 0);
    send_values(100, 200, 0);
    send_values(100, 0, 180);
    send_values(255, 255, 255);
    send_values(0, 255, 255);
    send_values(127, 128, 201);
    send_values(213, 77, 99);
  endtask

  task automatic test_half_rejects();
    set_mode(0, 1, 0);
    send_values(-1, 100, 100);
    send_values(32767, -32768, 0);
    send_values(32767, 32767, 32767);
    send_values(1000, 32767, 20000);
    set_mode(1, 1, 0);
    send_values(-5, 100, 100);
    send_values(16384, 32767, -20000);
    send_values(32767, 32767, 32767);
    send_values(5461, 20000, -1);
  endtask

  task automatic test_half_clamp();
    set_mode(0, 1, 1);
    send_values(-32768, -1, 5000);
    send_values(-100, 30000, -7);
    set_mode(1, 1, 1);
    send_values(-1, -1, 1234);
    send_values(20000, 32767, -32768);
  endtask

  // Random traffic across all modes and idle profiles.
  task automatic test_random_modes();
    int idle_sets[4][2] = '{'{0, 0}, '{57, 0}, '{0, 57}, '{19, 19}};
    for (int phase = 0; phase < 8; phase++) begin
      set_mode(phase[0], phase[1], phase[2]);
      for (int p = 0; p < 4; p++) begin
        send_idle_pct = idle_sets[p][0];
        recv_stall_pct = idle_sets[p][1];
        for (int j = 0; j < 12; j++) send_pixel(random_pixel());
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // The receiver holds off while the sender keeps offering, filling the pipe.
  task automatic test_backpressure();
    set_mode(0, 1, 0);
    hold_off_cycles = 120;
    send_burst(60);
    set_mode(1, 0, 0);
    hold_off_cycles = 60;
    send_burst(40);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_forward_bytes();
    test_reverse_bytes();
    test_half_rejects();
    test_half_clamp();
    test_random_modes();
    test_backpressure();
    req_valid <= 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0) begin
      $display("rgb_hsv_pixel_converter: match");
    end else begin
      $display("rgb_hsv_pixel_converter: mismatch");
    end
    $finish;
  end
endmodule
